### src/zsd_pkg.sv
package zsd_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int CHAR_WIDTH = 8;
   localparam int RESULT_WIDTH = 32;
   localparam int COUNT_WIDTH = 16;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ONE = 8'h31;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      status_type status;
      logic [RESULT_WIDTH-1:0] value;
      logic [COUNT_WIDTH-1:0] consumed_count;
   } rsp_word_type;

   function automatic logic is_binary_char(input logic [CHAR_WIDTH-1:0] c);
      return (c == CHAR_ZERO) || (c == CHAR_ONE);
   endfunction

endpackage

### src/zsd_req_if.sv
interface zsd_req_if import zsd_pkg::*; ();
   logic valid;
   logic ready;
   logic [CHAR_WIDTH-1:0] char_in;

   modport source(output valid, output char_in, input ready);
   modport sink(input valid, input char_in, output ready);
endinterface

### src/zsd_rsp_if.sv
interface zsd_rsp_if import zsd_pkg::*; ();
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [RESULT_WIDTH-1:0] value;
   logic [COUNT_WIDTH-1:0] consumed_count;

   modport source(output valid, output status, output value, output consumed_count, input ready);
   modport sink(input valid, input status, input value, input consumed_count, output ready);
endinterface

### src/zsd_core.sv
module zsd_core import zsd_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  logic [CHAR_WIDTH-1:0] char_in,
   output rsp_word_type result
);

   logic [VALUE_WIDTH-1:0] value_sum_ff, value_sum_in;
   logic [VALUE_WIDTH-1:0] shadow_sum_ff, shadow_sum_in;
   logic overflow_seen_ff, overflow_seen_in;
   logic [COUNT_WIDTH-1:0] char_count_ff, char_count_in;
   logic pending_digit_ff, pending_digit_in;
   logic last_folded_one_ff, last_folded_one_in;
   logic adjacent_error_ff, adjacent_error_in;

   logic is_bin;
   logic [VALUE_WIDTH+1:0] full_sum;
   logic [VALUE_WIDTH:0] shadow_next;
   logic fold_ovf;
   logic [RESULT_WIDTH-1:0] value_low;

   assign is_bin = is_binary_char(char_in);

   // S' = S + T + d, T' = S + d, with one guard bit pair for the carry out
   assign full_sum = {2'b00, value_sum_ff} + {2'b00, shadow_sum_ff}
                   + {{(VALUE_WIDTH+1){1'b0}}, pending_digit_ff};
   assign shadow_next = {1'b0, value_sum_ff} + {{VALUE_WIDTH{1'b0}}, pending_digit_ff};
   assign fold_ovf = (|full_sum[VALUE_WIDTH+1:VALUE_WIDTH]) | shadow_next[VALUE_WIDTH];

   generate
      if (VALUE_WIDTH >= RESULT_WIDTH) begin : g_wide
         assign value_low = value_sum_ff[RESULT_WIDTH-1:0];
      end else begin : g_narrow
         assign value_low = {{(RESULT_WIDTH-VALUE_WIDTH){1'b0}}, value_sum_ff};
      end
   endgenerate

   always_comb begin
      result.consumed_count = char_count_ff;
      result.value = '0;
      if ((char_count_ff < COUNT_WIDTH'(2)) || !pending_digit_ff || adjacent_error_ff) begin
         result.status = STATUS_INVALID;
      end else if (overflow_seen_ff) begin
         result.status = STATUS_OVERFLOW;
      end else begin
         result.status = STATUS_OK;
         result.value = value_low;
      end
   end

   always_comb begin
      value_sum_in = value_sum_ff;
      shadow_sum_in = shadow_sum_ff;
      overflow_seen_in = overflow_seen_ff;
      char_count_in = char_count_ff;
      pending_digit_in = pending_digit_ff;
      last_folded_one_in = last_folded_one_ff;
      adjacent_error_in = adjacent_error_ff;
      if (step) begin
         if (is_bin) begin
            // the held digit is folded only once a later binary char shows it is no terminator
            if (char_count_ff != '0) begin
               value_sum_in = full_sum[VALUE_WIDTH-1:0];
               shadow_sum_in = shadow_next[VALUE_WIDTH-1:0];
               overflow_seen_in = overflow_seen_ff | fold_ovf;
               last_folded_one_in = pending_digit_ff;
               adjacent_error_in = adjacent_error_ff | (pending_digit_ff & last_folded_one_ff);
            end
            pending_digit_in = (char_in == CHAR_ONE);
            if (char_count_ff != COUNT_MAX) begin
               char_count_in = char_count_ff + COUNT_WIDTH'(1);
            end
         end else begin
            value_sum_in = '0;
            shadow_sum_in = '0;
            overflow_seen_in = 1'b0;
            char_count_in = '0;
            pending_digit_in = 1'b0;
            last_folded_one_in = 1'b0;
            adjacent_error_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_sum_ff <= '0;
         shadow_sum_ff <= '0;
         overflow_seen_ff <= 1'b0;
         char_count_ff <= '0;
         pending_digit_ff <= 1'b0;
         last_folded_one_ff <= 1'b0;
         adjacent_error_ff <= 1'b0;
      end else begin
         value_sum_ff <= value_sum_in;
         shadow_sum_ff <= shadow_sum_in;
         overflow_seen_ff <= overflow_seen_in;
         char_count_ff <= char_count_in;
         pending_digit_ff <= pending_digit_in;
         last_folded_one_ff <= last_folded_one_in;
         adjacent_error_ff <= adjacent_error_in;
      end
   end

   a_clear_after_token: assert property (@(posedge clock) disable iff (reset)
      step && !is_bin |=> char_count_ff == '0 && value_sum_ff == '0 && !overflow_seen_ff)
      else $error("token state not cleared after ending char");

   a_empty_is_clean: assert property (@(posedge clock) disable iff (reset)
      char_count_ff == '0 |-> !pending_digit_ff && !adjacent_error_ff && shadow_sum_ff == '0)
      else $error("state left over with no binary chars counted");

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      step && is_bin && char_count_ff == COUNT_MAX |=> char_count_ff == COUNT_MAX)
      else $error("char count wrapped");

endmodule

### src/zeckendorf_string_decoder.sv
// Fibonacci-code decoder: takes one character word per cycle on req_bus. Runs of '0'/'1'
// are decoded on the fly (two running accumulators, S + T + d and S + d); any other
// character ends the token and yields one result word on rsp_bus with status, value and
// binary character count. The ending character passes through the input register, and
// rsp_bus.valid rises at the clock edge that moves it out of the input register into the
// result register. Binary characters yield no result. Throughput is one character per
// cycle, set by the accumulator update; an ending character stalls only while the result
// register is still full and rsp_bus.ready is low.
module zeckendorf_string_decoder import zsd_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   zsd_req_if.sink req_bus,
   zsd_rsp_if.source rsp_bus
);

   logic in_valid_ff, in_valid_in;
   logic [CHAR_WIDTH-1:0] in_char_ff, in_char_in;
   logic out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff, out_word_in;

   logic req_take;
   logic in_is_term;
   logic out_free;
   logic step;
   rsp_word_type core_result;

   zsd_core #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .step(step),
      .char_in(in_char_ff),
      .result(core_result)
   );

   assign in_is_term = !is_binary_char(in_char_ff);
   assign out_free = !out_valid_ff || rsp_bus.ready;
   // binary chars never need the result register, so they always move on
   assign step = in_valid_ff && (!in_is_term || out_free);
   assign req_bus.ready = !in_valid_ff || step;
   assign req_take = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in = in_char_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_char_in = req_bus.char_in;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_word_in = out_word_ff;
      if (step && in_is_term) begin
         out_valid_in = 1'b1;
         out_word_in = core_result;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_char_ff <= in_char_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.status = out_word_ff.status;
   assign rsp_bus.value = out_word_ff.value;
   assign rsp_bus.consumed_count = out_word_ff.consumed_count;

   a_fail_value_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_word_ff.status != STATUS_OK |-> out_word_ff.value == '0)
      else $error("nonzero value on failed token");

   a_held_char: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_char_ff))
      else $error("stalled input word lost");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_bus.ready |=> out_valid_ff && $stable(out_word_ff))
      else $error("pending result word overwritten");

endmodule

### verif/zeckendorf_string_decoder_tb.sv
`timescale 1ns / 1ps

module zeckendorf_string_decoder_tb;
   import zsd_pkg::*;

   localparam int VALUE_WIDTH = VALUE_WIDTH_DEFAULT;
   localparam logic [64:0] SUM_MASK = (65'd1 << VALUE_WIDTH) - 65'd1;
   localparam int RANDOM_ITEMS = 1560;
   localparam int QUIET_ITEMS = 300;
   localparam int DRAIN_LIMIT = 2000;
   localparam int N_ROWS = 17;

   // one directed token: head digits, a run of fill chars, tail digits, then the ending char
   typedef struct {
      int unsigned head_len;
      logic [63:0] head_bits;
      int unsigned fill_len;
      logic [7:0] fill_char;
      int unsigned tail_len;
      logic [7:0] tail_bits;
      logic [7:0] end_char;
      bit typed;
      rsp_word_type word;
   } token_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   zsd_req_if req_if ();
   zsd_rsp_if rsp_if ();

   zeckendorf_string_decoder #(.VALUE_WIDTH(VALUE_WIDTH)) u_top (
      .clock(clock),
      .reset(reset),
      .req_bus(req_if),
      .rsp_bus(rsp_if)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // decoder state mirror
   logic [63:0] fib_sum;
   logic [63:0] fib_shadow;
   bit fib_overflow;
   logic [15:0] bin_count;
   bit held_digit;
   bit prev_one;
   bit adjacent_ones;

   rsp_word_type expected_words[$];
   int error_count = 0;
   int items_sent = 0;
   bit quiet_mode = 1'b0;
   token_row_type dir_tab [N_ROWS];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] MISMATCH %s: got %0h expected %0h", $time, what, got, want);
      error_count++;
   endtask

   function automatic logic [63:0] wrap_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] r;
      r = {1'b0, a} + {1'b0, b};
      if (r > SUM_MASK)
         fib_overflow = 1'b1;
      return r[63:0] & SUM_MASK[63:0];
   endfunction

   task automatic clear_decoder();
      fib_sum = '0;
      fib_shadow = '0;
      fib_overflow = 1'b0;
      bin_count = '0;
      held_digit = 1'b0;
      prev_one = 1'b0;
      adjacent_ones = 1'b0;
   endtask

   task automatic fold_held(input bit d);
      logic [63:0] s;
      logic [63:0] t;
      logic [63:0] dv;
      s = fib_sum;
      t = fib_shadow;
      dv = {63'd0, d};
      if (d && prev_one)
         adjacent_ones = 1'b1;
      prev_one = d;
      fib_sum = wrap_add(wrap_add(s, t), dv);
      fib_shadow = wrap_add(s, dv);
   endtask

   task automatic fib_decode_char(input logic [7:0] c, output bit got, output rsp_word_type w);
      got = 1'b0;
      w = '0;
      if (c == CHAR_ZERO || c == CHAR_ONE) begin
         if (bin_count != 0)
            fold_held(held_digit);
         held_digit = (c == CHAR_ONE);
         if (bin_count != COUNT_MAX)
            bin_count++;
      end else begin
         got = 1'b1;
         if (bin_count < 2 || !held_digit || adjacent_ones) begin
            w.status = STATUS_INVALID;
         end else if (fib_overflow) begin
            w.status = STATUS_OVERFLOW;
         end else begin
            w.status = STATUS_OK;
            w.value = fib_sum[31:0];
         end
         w.consumed_count = bin_count;
         clear_decoder();
      end
   endtask

   // drive one char word, wait for acceptance, then log what it should produce
   task automatic send_char(input logic [7:0] c, input bit use_typed, input rsp_word_type typed);
      bit got;
      rsp_word_type w;
      @(negedge clock);
      if (!quiet_mode && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         req_if.char_in <= 8'($urandom);
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.char_in <= c;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      items_sent++;
      fib_decode_char(c, got, w);
      if (got)
         expected_words.push_back(use_typed ? typed : w);
   endtask

   task automatic send_bin(input bit d);
      send_char(d ? CHAR_ONE : CHAR_ZERO, 1'b0, '0);
   endtask

   function automatic logic [7:0] pick_end_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (c == CHAR_ZERO || c == CHAR_ONE)
         c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   task automatic run_row(input token_row_type r);
      for (int i = int'(r.head_len) - 1; i >= 0; i--)
         send_bin(r.head_bits[i]);
      repeat (r.fill_len) send_char(r.fill_char, 1'b0, '0);
      for (int i = int'(r.tail_len) - 1; i >= 0; i--)
         send_bin(r.tail_bits[i]);
      send_char(r.end_char, r.typed, r.word);
   endtask

   task automatic random_token();
      int kind;
      int len;
      bit d;
      bit last;
      kind = $urandom_range(0, 99);
      if (kind < 88) begin
         // well-formed code, mostly in range, some past the overflow edge
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(44, 52) : $urandom_range(1, 44);
         last = 1'b0;
         for (int i = 0; i < len; i++) begin
            d = last ? 1'b0 : 1'($urandom);
            // broken codes: force a one at the midpoint, an adjacent pair when the digit before is a one
            if (kind >= 80 && kind < 84 && i == len / 2)
               d = 1'b1;
            send_bin(d);
            last = d;
         end
         // bad terminator now and then
         send_bin(!(kind >= 84 && kind < 88));
      end else begin
         // noise: mixed bytes, binary-heavy
         len = $urandom_range(0, 8);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 1) == 0)
               send_bin(1'($urandom));
            else
               send_char(8'($urandom_range(0, 255)), 1'b0, '0);
         end
      end
      send_char(pick_end_char(), 1'b0, '0);
   endtask

   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("word with nothing expected", rsp_if.value, 32'd0);
         end else begin
            w = expected_words.pop_front();
            if (rsp_if.status !== w.status)
               report_mismatch("status", {30'd0, rsp_if.status}, {30'd0, w.status});
            if (rsp_if.value !== w.value)
               report_mismatch("value", rsp_if.value, w.value);
            if (rsp_if.consumed_count !== w.consumed_count)
               report_mismatch("consumed_count", {16'd0, rsp_if.consumed_count},
                               {16'd0, w.consumed_count});
         end
      end
   end

   // result side back-pressure
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int start;
      int waited;
      req_if.valid = 1'b0;
      req_if.char_in = '0;
      clear_decoder();
      dir_tab = '{
         '{0, 64'h0, 0, CHAR_ZERO, 0, 8'h0, 8'h20, 1'b1, '{STATUS_INVALID, 32'd0, 16'd0}},
         '{1, 64'h1, 0, CHAR_ZERO, 0, 8'h0, 8'h00, 1'b1, '{STATUS_INVALID, 32'd0, 16'd1}},
         '{1, 64'h0, 0, CHAR_ZERO, 0, 8'h0, 8'hFF, 1'b1, '{STATUS_INVALID, 32'd0, 16'd1}},
         '{2, 64'h3, 0, CHAR_ZERO, 0, 8'h0, 8'h32, 1'b1, '{STATUS_OK, 32'd1, 16'd2}},
         '{2, 64'h1, 0, CHAR_ZERO, 0, 8'h0, 8'h2F, 1'b1, '{STATUS_OK, 32'd0, 16'd2}},
         '{2, 64'h2, 0, CHAR_ZERO, 0, 8'h0, 8'h0A, 1'b1, '{STATUS_INVALID, 32'd0, 16'd2}},
         // ones next to the terminator are legal
         '{4, 64'hB, 0, CHAR_ZERO, 0, 8'h0, 8'h2C, 1'b1, '{STATUS_OK, 32'd4, 16'd4}},
         '{4, 64'hD, 0, CHAR_ZERO, 0, 8'h0, 8'h80, 1'b1, '{STATUS_INVALID, 32'd0, 16'd4}},
         '{4, 64'h1, 0, CHAR_ZERO, 0, 8'h0, 8'h7F, 1'b1, '{STATUS_OK, 32'd0, 16'd4}},
         // largest single weight that fits, then the first that does not
         '{1, 64'h1, 45, CHAR_ZERO, 1, 8'h1, 8'h20, 1'b1,
           '{STATUS_OK, 32'd2971215073, 16'd47}},
         '{1, 64'h1, 46, CHAR_ZERO, 1, 8'h1, 8'h20, 1'b1, '{STATUS_OVERFLOW, 32'd0, 16'd48}},
         // invalid wins over overflow
         '{2, 64'h3, 46, CHAR_ZERO, 1, 8'h1, 8'h3A, 1'b1, '{STATUS_INVALID, 32'd0, 16'd49}},
         '{45, 64'h15555555555, 0, CHAR_ZERO, 0, 8'h0, 8'h41, 1'b0, '0},
         '{47, 64'h555555555555, 0, CHAR_ZERO, 0, 8'h0, 8'h2E, 1'b0, '0},
         '{13, 64'h1253, 0, CHAR_ZERO, 0, 8'h0, 8'h5A, 1'b0, '0},
         '{0, 64'h0, 0, CHAR_ZERO, 0, 8'h0, 8'h2F, 1'b1, '{STATUS_INVALID, 32'd0, 16'd0}},
         '{2, 64'h3, 0, CHAR_ZERO, 0, 8'h0, 8'h01, 1'b1, '{STATUS_OK, 32'd1, 16'd2}}
      };

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i])
         run_row(dir_tab[i]);

      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         if (items_sent - start >= RANDOM_ITEMS - QUIET_ITEMS)
            quiet_mode = 1'b1;
         random_token();
      end

      @(negedge clock);
      req_if.valid <= 1'b0;

      waited = 0;
      while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (expected_words.size() != 0)
         report_mismatch("words never returned", expected_words.size(), 32'd0);

      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

### filelist.f
src/zsd_pkg.sv
src/zsd_req_if.sv
src/zsd_rsp_if.sv
src/zsd_core.sv
src/zeckendorf_string_decoder.sv
verif/zeckendorf_string_decoder_tb.sv
